>>> sv/ppmhp_pkg.sv
package ppmhp_pkg;

  // Largest image side that a header may declare
  localparam logic [16:0] MaxDim = 17'd4096;
  // Largest maxval that a header may declare
  localparam logic [16:0] MaxVal = 17'd65535;
  // Decimal accumulator saturates here
  localparam logic [16:0] NumSat = 17'd65536;
  // Header byte counter saturates here
  localparam logic [12:0] HdrSat = 13'd8191;

  // Stream characters
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChSix   = 8'h36;

  // Only this format and maxval are carried through to pixels
  localparam logic [2:0]  FmtRgbBinary = 3'd6;
  localparam logic [16:0] MaxVal8      = 17'd255;
  localparam logic [2:0]  FmtBitAscii  = 3'd1;
  localparam logic [2:0]  FmtBitBinary = 3'd4;

  // Configuration register indices
  localparam logic [2:0] CfgTargetWidth   = 3'd0;
  localparam logic [2:0] CfgTargetHeight  = 3'd1;
  localparam logic [2:0] CfgLandscapeMode = 3'd2;
  localparam logic [2:0] CfgTargetPresent = 3'd3;
  localparam logic [2:0] CfgHeaderLimit   = 3'd4;

  typedef enum logic [1:0] {
    EvPixel     = 2'd0,
    EvHeaderOk  = 2'd1,
    EvHeaderErr = 2'd2,
    EvMismatch  = 2'd3
  } ev_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    ev_e         event_res;
    logic [23:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        image_done;
  } out_t;

  typedef struct packed {
    logic [12:0] target_width;
    logic [12:0] target_height;
    logic        landscape_mode;
    logic        target_present;
    logic [12:0] header_limit;
  } cfg_t;

  // Classified word handed from the parser to the pixel writer
  typedef struct packed {
    ev_e         ev;
    logic [12:0] mul_a;
    logic [12:0] mul_b;
    logic [12:0] add;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        done;
  } rec_t;

endpackage

>>> sv/ppmhp_fifo.sv
module ppmhp_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ppmhp_pkg::rec_t push_data_i,
  output logic            not_full_o,
  input  logic            pop_i,
  output logic            not_empty_o,
  output ppmhp_pkg::rec_t pop_data_o
);
  import ppmhp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  rec_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign not_full_o  = (cnt_q != CntW'(DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_data_o  = mem_q[rd_ptr_q];

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with occupancy");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

>>> sv/ppmhp_front.sv
module ppmhp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ppmhp_pkg::in_t  in_i,
  input  ppmhp_pkg::cfg_t cfg_i,
  output logic            rec_valid_o,
  output ppmhp_pkg::rec_t rec_o,
  input  logic            rec_ready_i
);
  import ppmhp_pkg::*;

  typedef enum logic [3:0] {
    PhSearch = 4'd0,
    PhFormat = 4'd1,
    PhWSkip  = 4'd2,
    PhWDig   = 4'd3,
    PhHSkip  = 4'd4,
    PhHDig   = 4'd5,
    PhMSkip  = 4'd6,
    PhMDig   = 4'd7,
    PhLf     = 4'd8,
    PhPix    = 4'd9
  } phase_e;

  phase_e      phase_q, phase_d, dig_ph;
  logic [2:0]  fmt_q, fmt_d;
  logic [12:0] w_q, w_d, h_q, h_d;
  logic [16:0] max_q, max_d, acc_q, acc_d;
  logic        inc_q, inc_d;
  logic [12:0] hb_q, hb_d;
  logic [12:0] col_q, col_d, row_q, row_d;
  logic [1:0]  bp_q, bp_d;
  logic [7:0]  red_q, red_d, grn_q, grn_d;

  logic        accept, emit, failed, do_skip, do_lf, size_ok;
  logic [7:0]  c;
  logic        is_dig;
  logic [3:0]  dig;
  logic [19:0] acc_w;
  rec_t        rec;

  assign in_ready_o  = rec_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign rec_valid_o = accept && emit;
  assign rec_o       = rec;

  assign c      = in_i.data_byte;
  assign is_dig = (c >= ChZero) && (c <= ChNine);
  assign dig    = 4'(c - ChZero);
  assign acc_w  = ({3'b0, acc_q} << 3) + ({3'b0, acc_q} << 1) + {16'b0, dig};

  // Classify one byte against the header grammar or the pixel stream
  always_comb begin
    phase_d = phase_q;
    fmt_d   = fmt_q;
    w_d     = w_q;
    h_d     = h_q;
    max_d   = max_q;
    acc_d   = acc_q;
    inc_d   = inc_q;
    hb_d    = hb_q;
    col_d   = col_q;
    row_d   = row_q;
    bp_d    = bp_q;
    red_d   = red_q;
    grn_d   = grn_q;
    emit    = 1'b0;
    failed  = 1'b0;
    do_skip = 1'b0;
    do_lf   = 1'b0;
    dig_ph  = PhWDig;
    size_ok = 1'b1;
    rec     = '0;
    rec.ev  = EvHeaderErr;

    // Restart drops back to the search before the byte is looked at
    if (in_i.restart) begin
      phase_d = PhSearch;
      inc_d   = 1'b0;
      bp_d    = 2'd0;
      hb_d    = '0;
    end

    if (phase_d == PhPix) begin
      case (bp_d)
        2'd0: begin
          red_d = c;
          bp_d  = 2'd1;
        end
        2'd1: begin
          grn_d = c;
          bp_d  = 2'd2;
        end
        default: begin
          bp_d      = 2'd0;
          rec.ev    = EvPixel;
          rec.red   = red_q;
          rec.green = grn_q;
          rec.blue  = c;
          if (cfg_i.landscape_mode) begin
            rec.mul_a = col_q;
            rec.mul_b = h_q;
            rec.add   = h_q - 13'd1 - row_q;
          end else begin
            rec.mul_a = row_q;
            rec.mul_b = w_q;
            rec.add   = col_q;
          end
          col_d = col_q + 13'd1;
          if (col_d >= w_q) begin
            col_d = '0;
            row_d = row_q + 13'd1;
            if (row_d >= h_q) begin
              rec.done = 1'b1;
              row_d    = '0;
              phase_d  = PhSearch;
            end
          end
          emit = cfg_i.target_present;
        end
      endcase
    end else if (phase_d == PhSearch) begin
      if (c == ChP) begin
        phase_d = PhFormat;
        inc_d   = 1'b0;
        hb_d    = 13'd1;
        if (hb_d > cfg_i.header_limit) begin
          failed = 1'b1;
        end
      end
    end else begin
      if (hb_d < HdrSat) begin
        hb_d = hb_d + 13'd1;
      end
      if (hb_d > cfg_i.header_limit) begin
        failed = 1'b1;
      end else begin
        case (phase_d)
          PhFormat: begin
            if (c >= ChOne && c <= ChSix) begin
              fmt_d   = 3'(c - ChZero);
              phase_d = PhWSkip;
            end else begin
              failed = 1'b1;
            end
          end
          PhWSkip: begin
            do_skip = 1'b1;
            dig_ph  = PhWDig;
          end
          PhHSkip: begin
            do_skip = 1'b1;
            dig_ph  = PhHDig;
          end
          PhMSkip: begin
            do_skip = 1'b1;
            dig_ph  = PhMDig;
          end
          PhWDig, PhHDig, PhMDig: begin
            if (is_dig) begin
              acc_d = (acc_w > {3'b0, NumSat}) ? NumSat : acc_w[16:0];
            end else if (phase_d == PhWDig) begin
              if (acc_q == '0 || acc_q > MaxDim) begin
                failed = 1'b1;
              end else begin
                w_d     = acc_q[12:0];
                phase_d = PhHSkip;
                inc_d   = 1'b0;
                do_skip = 1'b1;
              end
            end else if (phase_d == PhHDig) begin
              if (acc_q == '0 || acc_q > MaxDim) begin
                failed = 1'b1;
              end else begin
                h_d   = acc_q[12:0];
                inc_d = 1'b0;
                if (fmt_q == FmtBitAscii || fmt_q == FmtBitBinary) begin
                  max_d   = 17'd1;
                  phase_d = PhLf;
                  do_lf   = 1'b1;
                end else begin
                  phase_d = PhMSkip;
                  do_skip = 1'b1;
                end
              end
            end else begin
              if (acc_q == '0 || acc_q > MaxVal) begin
                failed = 1'b1;
              end else begin
                max_d   = acc_q;
                phase_d = PhLf;
                inc_d   = 1'b0;
                do_lf   = 1'b1;
              end
            end
          end
          PhLf: begin
            do_lf = 1'b1;
          end
          default: begin
            phase_d = PhSearch;
          end
        endcase

        // Skip whitespace and comments ahead of a number
        if (do_skip) begin
          if (inc_d) begin
            if (c == ChLf || c == ChCr) begin
              inc_d = 1'b0;
            end
          end else if (is_dig) begin
            acc_d   = {13'b0, dig};
            phase_d = dig_ph;
          end else if (c == ChHash) begin
            inc_d = 1'b1;
          end else if (c > ChSpace) begin
            failed = 1'b1;
          end
        end

        // Close the header on the single line feed
        if (do_lf) begin
          if (c != ChLf) begin
            failed = 1'b1;
          end else begin
            if (cfg_i.landscape_mode) begin
              size_ok = (cfg_i.target_width == h_d) && (cfg_i.target_height == w_d);
            end else begin
              size_ok = (cfg_i.target_width == w_d) && (cfg_i.target_height == h_d);
            end
            if (fmt_d != FmtRgbBinary || max_d != MaxVal8 ||
                (cfg_i.target_present && !size_ok)) begin
              phase_d = PhSearch;
              inc_d   = 1'b0;
              emit    = 1'b1;
              rec.ev  = EvMismatch;
            end else begin
              col_d   = '0;
              row_d   = '0;
              bp_d    = 2'd0;
              phase_d = PhPix;
              emit    = 1'b1;
              rec.ev  = EvHeaderOk;
            end
          end
        end
      end
    end

    // Drop back to the search on a header error
    if (failed) begin
      phase_d = PhSearch;
      inc_d   = 1'b0;
      emit    = 1'b1;
      rec     = '0;
      rec.ev  = EvHeaderErr;
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSearch;
      fmt_q   <= '0;
      w_q     <= '0;
      h_q     <= '0;
      max_q   <= '0;
      acc_q   <= '0;
      inc_q   <= 1'b0;
      hb_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
      bp_q    <= '0;
      red_q   <= '0;
      grn_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      fmt_q   <= fmt_d;
      w_q     <= w_d;
      h_q     <= h_d;
      max_q   <= max_d;
      acc_q   <= acc_d;
      inc_q   <= inc_d;
      hb_q    <= hb_d;
      col_q   <= col_d;
      row_q   <= row_d;
      bp_q    <= bp_d;
      red_q   <= red_d;
      grn_q   <= grn_d;
    end
  end

  a_pix_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPix) |-> (w_q != '0 && h_q != '0))
    else $error("pixel phase with an empty image");

  a_pix_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPix) |-> (col_q < w_q && row_q < h_q))
    else $error("pixel position outside the image");

  a_bp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bp_q != 2'd3)
    else $error("byte phase out of range");

endmodule

>>> sv/ppmhp_back.sv
module ppmhp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rec_valid_i,
  output logic             rec_ready_o,
  input  ppmhp_pkg::rec_t  rec_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ppmhp_pkg::out_t  out_o
);
  import ppmhp_pkg::*;

  logic        s1_valid_q;
  ev_e         s1_ev_q;
  logic [25:0] s1_prod_q;
  logic [12:0] s1_add_q;
  logic [7:0]  s1_red_q, s1_grn_q, s1_blu_q;
  logic        s1_done_q;
  logic        s2_valid_q;
  out_t        s2_q;
  logic        s1_ready, s2_ready;
  logic [23:0] idx;

  assign s2_ready    = !s2_valid_q || out_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign rec_ready_o = s1_ready;
  assign out_valid_o = s2_valid_q;
  assign out_o       = s2_q;
  assign idx         = s1_prod_q[23:0] + {11'b0, s1_add_q};

  // Valid flags of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= rec_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Multiply row or column by the image side
  always_ff @(posedge clk_i) begin
    if (s1_ready && rec_valid_i) begin
      s1_ev_q   <= rec_i.ev;
      s1_prod_q <= rec_i.mul_a * rec_i.mul_b;
      s1_add_q  <= rec_i.add;
      s1_red_q  <= rec_i.red;
      s1_grn_q  <= rec_i.green;
      s1_blu_q  <= rec_i.blue;
      s1_done_q <= rec_i.done;
    end
  end

  // Add the offset and present the word
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_q.event_res   <= s1_ev_q;
      s2_q.pixel_index <= idx;
      s2_q.red         <= s1_red_q;
      s2_q.green       <= s1_grn_q;
      s2_q.blue        <= s1_blu_q;
      s2_q.image_done  <= s1_done_q;
    end
  end

endmodule

>>> sv/ppm_header_parse_pixel_writer_top.sv
// Channel  | Signals                            | Moves
// ---------+------------------------------------+--------------------------------
// input    | in_valid_i, in_ready_o, in_i       | one stream byte and restart flag
// output   | out_valid_o, out_ready_i, out_o    | one event or pixel write word
// config   | cfg_we_i, cfg_idx_i, cfg_wdata_i   | one register write, no wait
//
// Takes one byte every cycle while the queue has room; the parser decides each
// byte combinationally. A result passes through the queue, the index multiplier
// stage and the offset adder stage into the output register.
// A queue of QUEUE_DEPTH words parts parser and writer, so the input keeps
// flowing while the output is stalled until the queue and both stages fill.
// Reset returns to the 'P' search and loads the register defaults at once.
module ppm_header_parse_pixel_writer_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ppmhp_pkg::in_t   in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ppmhp_pkg::out_t  out_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [12:0]      cfg_wdata_i
);
  import ppmhp_pkg::*;

  cfg_t cfg_q;
  rec_t push_rec, pop_rec;
  logic push_valid, q_not_full, q_not_empty, pop_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_width   <= 13'd612;
      cfg_q.target_height  <= 13'd792;
      cfg_q.landscape_mode <= 1'b0;
      cfg_q.target_present <= 1'b1;
      cfg_q.header_limit   <= 13'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTargetWidth:   cfg_q.target_width   <= cfg_wdata_i;
        CfgTargetHeight:  cfg_q.target_height  <= cfg_wdata_i;
        CfgLandscapeMode: cfg_q.landscape_mode <= cfg_wdata_i[0];
        CfgTargetPresent: cfg_q.target_present <= cfg_wdata_i[0];
        CfgHeaderLimit:   cfg_q.header_limit   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ppmhp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .rec_valid_o (push_valid),
    .rec_o       (push_rec),
    .rec_ready_i (q_not_full)
  );

  ppmhp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_rec),
    .not_full_o  (q_not_full),
    .pop_i       (pop_ready),
    .not_empty_o (q_not_empty),
    .pop_data_o  (pop_rec)
  );

  ppmhp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_not_empty),
    .rec_ready_o (pop_ready),
    .rec_i       (pop_rec),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppmhp_pkg::*;

  // How a directed row is checked
  typedef enum logic [1:0] {
    ByModel     = 2'd0,
    NoResult    = 2'd1,
    GivenResult = 2'd2
  } row_kind_e;

  // Header walk of the decoder model
  typedef enum logic [3:0] {
    HuntP, TakeFmt, SkipW, DigW, SkipH, DigH, SkipM, DigM, WantLf, InPixels
  } parse_e;

  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    row_kind_e  kind;
    out_t       want;
  } dir_row_t;

  localparam out_t Blank  = '0;
  localparam out_t ErrOut = '{EvHeaderErr, 24'd0, 8'd0, 8'd0, 8'd0, 1'b0};
  localparam out_t MisOut = '{EvMismatch, 24'd0, 8'd0, 8'd0, 8'd0, 1'b0};
  localparam out_t OkOut  = '{EvHeaderOk, 24'd0, 8'd0, 8'd0, 8'd0, 1'b0};
  localparam out_t PixOut = '{EvPixel, 24'd0, 8'hff, 8'h00, 8'h80, 1'b0};

  localparam int NumRows = 31;

  // Directed stream, run with the reset settings (612 x 792 portrait)
  localparam dir_row_t DirRows [NumRows] = '{
    '{"x",     1'b0, NoResult,    Blank},   // dropped while hunting
    '{ChP,     1'b0, NoResult,    Blank},
    '{"7",     1'b0, GivenResult, ErrOut},  // format digit out of range
    '{ChP,     1'b0, ByModel,     Blank},
    '{"4",     1'b0, ByModel,     Blank},   // bitmap format, no maxval
    '{ChHash,  1'b0, ByModel,     Blank},   // comment closed by CR
    '{ChCr,    1'b0, ByModel,     Blank},
    '{"1",     1'b0, ByModel,     Blank},
    '{"9",     1'b0, ByModel,     Blank},
    '{8'h00,   1'b0, ByModel,     Blank},   // lowest byte is whitespace
    '{"1",     1'b0, ByModel,     Blank},
    '{ChLf,    1'b0, GivenResult, MisOut},  // bitmap always mismatches
    '{ChP,     1'b1, ByModel,     Blank},   // restart flag on a 'P'
    '{"6",     1'b0, ByModel,     Blank},
    '{"6",     1'b0, ByModel,     Blank},   // width follows the digit directly
    '{"1",     1'b0, ByModel,     Blank},
    '{"2",     1'b0, ByModel,     Blank},
    '{ChSpace, 1'b0, ByModel,     Blank},
    '{"7",     1'b0, ByModel,     Blank},
    '{"9",     1'b0, ByModel,     Blank},
    '{"2",     1'b0, ByModel,     Blank},
    '{8'h09,   1'b0, ByModel,     Blank},
    '{"2",     1'b0, ByModel,     Blank},
    '{"5",     1'b0, ByModel,     Blank},
    '{"5",     1'b0, ByModel,     Blank},
    '{ChLf,    1'b0, GivenResult, OkOut},
    '{8'hff,   1'b0, ByModel,     Blank},
    '{8'h00,   1'b0, ByModel,     Blank},
    '{8'h80,   1'b0, GivenResult, PixOut},
    '{ChP,     1'b1, NoResult,    Blank},   // restart out of the pixel data
    '{8'hff,   1'b0, GivenResult, ErrOut}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid_q = 1'b0;
  in_t       in_word_q = '0;
  row_kind_e tag_kind_q = ByModel;
  out_t      tag_want_q = '0;
  logic      out_ready_q = 1'b0;
  logic      cfg_we_q = 1'b0;
  logic [2:0]  cfg_idx_q = CfgTargetWidth;
  logic [12:0] cfg_wdata_q = '0;

  logic  in_ready_o;
  logic  out_valid_o;
  out_t  out_o;

  // Model state and register copy
  cfg_t        settings;
  parse_e      st;
  int unsigned fmt, img_w, img_h, mval, acc, hdr_cnt, col, rw, rgb_sel;
  logic        comment_on;
  logic [7:0]  r_keep, g_keep;

  out_t        want_q [$];
  in_t         pend_q [$];
  int unsigned bad_words = 0;
  logic        calm = 1'b0;
  int unsigned cyc_cnt = 0;
  int unsigned ready_hold = 0;
  logic        restart_next = 1'b0;

  always #6 clk = ~clk;

  ppm_header_parse_pixel_writer_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (in_ready_o),
    .in_i        (in_word_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_q),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_q),
    .cfg_idx_i   (cfg_idx_q),
    .cfg_wdata_i (cfg_wdata_q)
  );

  function automatic int unsigned pause_len();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic clear_model();
    settings = '{13'd612, 13'd792, 1'b0, 1'b1, 13'd1024};
    st = HuntP;
    fmt = 0; img_w = 0; img_h = 0; mval = 0; acc = 0; hdr_cnt = 0;
    col = 0; rw = 0; rgb_sel = 0; comment_on = 1'b0; r_keep = '0; g_keep = '0;
  endtask

  // Abandon the header and go back to hunting for 'P'
  function automatic bit reject(input ev_e ev, output out_t res);
    st = HuntP;
    comment_on = 1'b0;
    res = '0;
    res.event_res = ev;
    return 1'b1;
  endfunction

  // Advance the decoder by one byte; returns 1 when a word is due
  function automatic bit decode_byte(input in_t w, output out_t res);
    logic [7:0]  c;
    int unsigned idx;
    logic        last;
    logic        fits;
    c = w.data_byte;
    res = '0;
    if (w.restart) begin
      st = HuntP; comment_on = 1'b0; rgb_sel = 0; hdr_cnt = 0;
    end

    // Gather R and G, emit on B
    if (st == InPixels) begin
      if (rgb_sel == 0) begin
        r_keep = c; rgb_sel = 1; return 1'b0;
      end
      if (rgb_sel == 1) begin
        g_keep = c; rgb_sel = 2; return 1'b0;
      end
      rgb_sel = 0;
      if (settings.landscape_mode) idx = col * img_h + (img_h - 1 - rw);
      else idx = rw * img_w + col;
      last = 1'b0;
      col++;
      if (col >= img_w) begin
        col = 0;
        rw++;
        if (rw >= img_h) begin
          last = 1'b1; rw = 0; st = HuntP;
        end
      end
      if (!settings.target_present) return 1'b0;
      res.event_res = EvPixel;
      res.pixel_index = idx[23:0];
      res.red = r_keep;
      res.green = g_keep;
      res.blue = c;
      res.image_done = last;
      return 1'b1;
    end

    if (st == HuntP) begin
      if (c != ChP) return 1'b0;
      st = TakeFmt; comment_on = 1'b0; hdr_cnt = 1;
      if (hdr_cnt > settings.header_limit) return reject(EvHeaderErr, res);
      return 1'b0;
    end

    if (hdr_cnt < HdrSat) hdr_cnt++;
    if (hdr_cnt > settings.header_limit) return reject(EvHeaderErr, res);

    // A non-digit closes the number and is handled again below
    if (st == DigW || st == DigH || st == DigM) begin
      if (c >= ChZero && c <= ChNine) begin
        acc = acc * 10 + (c - ChZero);
        if (acc > NumSat) acc = NumSat;
        return 1'b0;
      end
      if (acc == 0 || acc > ((st == DigM) ? MaxVal : MaxDim)) return reject(EvHeaderErr, res);
      case (st)
        DigW: begin
          img_w = acc; st = SkipH;
        end
        DigH: begin
          img_h = acc;
          if (fmt == FmtBitAscii || fmt == FmtBitBinary) begin
            mval = 1; st = WantLf;
          end else begin
            st = SkipM;
          end
        end
        default: begin
          mval = acc; st = WantLf;
        end
      endcase
      comment_on = 1'b0;
    end

    case (st)
      TakeFmt: begin
        if (c < ChOne || c > ChSix) return reject(EvHeaderErr, res);
        fmt = c - ChZero;
        st = SkipW;
        return 1'b0;
      end
      SkipW, SkipH, SkipM: begin
        if (comment_on) begin
          if (c == ChLf || c == ChCr) comment_on = 1'b0;
          return 1'b0;
        end
        if (c >= ChZero && c <= ChNine) begin
          acc = c - ChZero;
          case (st)
            SkipW:   st = DigW;
            SkipH:   st = DigH;
            default: st = DigM;
          endcase
          return 1'b0;
        end
        if (c == ChHash) begin
          comment_on = 1'b1;
          return 1'b0;
        end
        if (c > ChSpace) return reject(EvHeaderErr, res);
        return 1'b0;
      end
      WantLf: begin
        if (c != ChLf) return reject(EvHeaderErr, res);
        if (fmt != FmtRgbBinary || mval != MaxVal8) return reject(EvMismatch, res);
        if (settings.target_present) begin
          if (settings.landscape_mode)
            fits = (settings.target_width == img_h) && (settings.target_height == img_w);
          else
            fits = (settings.target_width == img_w) && (settings.target_height == img_h);
          if (!fits) return reject(EvMismatch, res);
        end
        col = 0; rw = 0; rgb_sel = 0;
        st = InPixels;
        res.event_res = EvHeaderOk;
        return 1'b1;
      end
      default: begin
        st = HuntP;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void note_bad(input string why, input out_t e, input out_t g);
    bad_words++;
    if (bad_words <= 10)
      $display("%0t %s: exp ev=%0d idx=%0h rgb=%h%h%h done=%0b got ev=%0d idx=%0h rgb=%h%h%h done=%0b",
               $time, why, e.event_res, e.pixel_index, e.red, e.green, e.blue, e.image_done,
               g.event_res, g.pixel_index, g.red, g.green, g.blue, g.image_done);
  endfunction

  // Predict on each accepted byte, then check each accepted word
  always @(posedge clk) begin
    out_t got;
    out_t exp_w;
    bit   hit;
    if (rst_n) begin
      if (in_valid_q && in_ready_o) begin
        hit = decode_byte(in_word_q, exp_w);
        if (tag_kind_q == GivenResult) want_q.push_back(tag_want_q);
        else if (tag_kind_q == ByModel && hit) want_q.push_back(exp_w);
      end
      if (out_valid_o && out_ready_q) begin
        got = out_o;
        if (want_q.size() == 0) begin
          note_bad("word with nothing expected", '0, got);
        end else begin
          exp_w = want_q.pop_front();
          if (got.event_res !== exp_w.event_res || got.pixel_index !== exp_w.pixel_index ||
              got.red !== exp_w.red || got.green !== exp_w.green ||
              got.blue !== exp_w.blue || got.image_done !== exp_w.image_done)
            note_bad("word mismatch", exp_w, got);
        end
      end
    end
  end

  // Stall the output side, with calm stretches now and then
  always @(posedge clk) begin
    int unsigned s;
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt % 160 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (!rst_n) begin
      out_ready_q <= 1'b0;
      ready_hold <= 0;
    end else if (out_ready_q) begin
      if (out_valid_o) begin
        s = pause_len();
        if (s != 0) begin
          out_ready_q <= 1'b0;
          ready_hold <= s;
        end
      end
    end else if (ready_hold <= 1) begin
      out_ready_q <= 1'b1;
      ready_hold <= 0;
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // Offer one word and hold it until taken
  task automatic send_word(input logic [7:0] b, input logic rs, input row_kind_e k,
                           input out_t want);
    int unsigned gap;
    gap = pause_len();
    if (gap != 0) begin
      in_valid_q <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_q <= 1'b1;
    in_word_q <= '{data_byte: b, restart: rs};
    tag_kind_q <= k;
    tag_want_q <= want;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
  endtask

  // Wait until every expected word is out, then let the pipe settle
  task automatic drain();
    in_valid_q <= 1'b0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic poke(input logic [2:0] idx, input logic [12:0] val);
    cfg_we_q <= 1'b1;
    cfg_idx_q <= idx;
    cfg_wdata_q <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    poke(CfgTargetWidth, s.target_width);
    poke(CfgTargetHeight, s.target_height);
    poke(CfgLandscapeMode, {12'd0, s.landscape_mode});
    poke(CfgTargetPresent, {12'd0, s.target_present});
    poke(CfgHeaderLimit, s.header_limit);
    cfg_we_q <= 1'b0;
    settings = s;
  endtask

  function automatic cfg_t pick_settings(input int unsigned n);
    cfg_t s;
    s.target_width = 13'($urandom_range(1, 4));
    s.target_height = 13'($urandom_range(1, 4));
    s.landscape_mode = 1'($urandom_range(0, 1));
    s.target_present = ($urandom_range(0, 4) != 0);
    s.header_limit = 13'($urandom_range(16, 4096));
    case (n)
      0: begin
        s.target_width = 13'd1; s.target_height = 13'd1; s.landscape_mode = 1'b0;
        s.target_present = 1'b1; s.header_limit = 13'd4096;
      end
      1: begin
        s.target_width = 13'd4096; s.target_height = 13'd1; s.landscape_mode = 1'b0;
        s.target_present = 1'b1; s.header_limit = 13'd16;
      end
      2: begin
        s.target_width = 13'd1; s.target_height = 13'd4096; s.landscape_mode = 1'b1;
        s.target_present = 1'b1; s.header_limit = 13'd1024;
      end
      3: begin
        s.landscape_mode = 1'b1; s.target_present = 1'b1;
      end
      4: begin
        s.target_present = 1'b0; s.header_limit = 13'($urandom_range(16, 64));
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    in_t w;
    w.data_byte = b;
    w.restart = restart_next;
    restart_next = 1'b0;
    pend_q.push_back(w);
  endtask

  task automatic put_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) queue_byte(ChZero);
    foreach (s[k]) queue_byte(s[k]);
  endtask

  // Whitespace, a comment, or now and then a stray byte
  task automatic put_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      queue_byte(ChHash);
      repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(8'h20, 8'h7e)));
      queue_byte($urandom_range(0, 1) ? ChCr : ChLf);
    end else if (r == 1) begin
      queue_byte("x");
    end else begin
      repeat ($urandom_range(1, 2)) queue_byte(8'($urandom_range(0, 32)));
    end
  endtask

  function automatic int unsigned pick_side(input int unsigned base);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 4097;
    if (r == 2) return 99999;
    if (r <= 4) return $urandom_range(1, 4);
    return base;
  endfunction

  // Mostly well-formed headers with pixel data, the rest noise
  task automatic build_sequence();
    int unsigned hw, hh, mv, total, cut;
    logic [7:0]  fmt_c, term;
    int unsigned odd_vals [7] = '{0, 1, 254, 256, 65535, 65536, 70000};
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 10)) begin
        restart_next |= ($urandom_range(0, 7) == 0);
        queue_byte(($urandom_range(0, 2) == 0) ? ChP : 8'($urandom_range(0, 255)));
      end
      return;
    end
    if ($urandom_range(0, 3) == 0) restart_next = 1'b1;
    if ($urandom_range(0, 3) == 0) queue_byte(8'($urandom_range(0, 255)));
    queue_byte(ChP);
    fmt_c = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(ChZero, 8'h38)) : ChSix;
    queue_byte(fmt_c);
    if (!settings.target_present) begin
      hw = pick_side($urandom_range(1, 4));
      hh = pick_side($urandom_range(1, 4));
    end else if (settings.landscape_mode) begin
      hw = pick_side(settings.target_height);
      hh = pick_side(settings.target_width);
    end else begin
      hw = pick_side(settings.target_width);
      hh = pick_side(settings.target_height);
    end
    if ($urandom_range(0, 2) != 0) put_gap();
    put_number(hw);
    put_gap();
    put_number(hh);
    mv = 255;
    if (fmt_c != "1" && fmt_c != "4") begin
      put_gap();
      if ($urandom_range(0, 9) == 0) mv = odd_vals[$urandom_range(0, 6)];
      put_number(mv);
    end
    case ($urandom_range(0, 29))
      0:       term = ChCr;
      1:       term = ChSpace;
      2:       term = "x";
      default: term = ChLf;
    endcase
    queue_byte(term);
    if (fmt_c == ChSix && mv == 255 && term == ChLf &&
        hw >= 1 && hw <= 4096 && hh >= 1 && hh <= 4096) begin
      total = hw * hh * 3;
      cut = total;
      if (total > 96 || $urandom_range(0, 9) == 0)
        cut = $urandom_range(0, (total > 96) ? 96 : total);
      repeat (cut) queue_byte(8'($urandom_range(0, 255)));
      if (cut < total) restart_next = 1'b1;
    end
  endtask

  initial begin
    in_t         w;
    int unsigned sent;
    clear_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table under the reset settings
    for (int i = 0; i < NumRows; i++)
      send_word(DirRows[i].data, DirRows[i].rs, DirRows[i].kind, DirRows[i].want);
    drain();

    // Random streams, one register setting per phase
    for (int unsigned p = 0; p < 7; p++) begin
      load_settings(pick_settings(p));
      sent = 0;
      while (sent < 75) begin
        build_sequence();
        while (pend_q.size() != 0) begin
          w = pend_q.pop_front();
          send_word(w.data_byte, w.restart, ByModel, Blank);
          sent++;
        end
      end
      drain();
    end

    repeat (12) @(posedge clk);
    if (bad_words == 0 && want_q.size() == 0) begin
      $display("[ppm_header_parse_pixel_writer_top] OK");
    end else begin
      $display("[ppm_header_parse_pixel_writer_top] ERROR");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #20_000_000;
    $display("[ppm_header_parse_pixel_writer_top] ERROR");
    $finish;
  end

endmodule
